[rtl/dqkt_pkg.sv]
package dqkt_pkg;

    localparam int DELAY_W = 14;
    localparam int LOSS_W  = 7;
    localparam int STEP_W  = 7;

    localparam logic [DELAY_W-1:0] DELAY_FULL      = 14'd16383;
    localparam logic [DELAY_W-1:0] DELAY_FINE_TOP  = 14'd100;
    localparam logic [DELAY_W-1:0] DELAY_MID_TOP   = 14'd1000;
    localparam logic [STEP_W-1:0]  STEP_FINE       = 7'd1;
    localparam logic [STEP_W-1:0]  STEP_MID        = 7'd10;
    localparam logic [STEP_W-1:0]  STEP_COARSE     = 7'd100;

    localparam logic [DELAY_W-1:0] DELAY_MIN_RST   = 14'd0;
    localparam logic [DELAY_W-1:0] DELAY_MAX_RST   = 14'd10000;
    localparam logic [LOSS_W-1:0]  LOSS_MIN_RST    = 7'd0;
    localparam logic [LOSS_W-1:0]  LOSS_MAX_RST    = 7'd100;

    typedef enum logic [1:0] {
        CFG_DELAY_MIN = 2'd0,
        CFG_DELAY_MAX = 2'd1,
        CFG_LOSS_MIN  = 2'd2,
        CFG_LOSS_MAX  = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic delay_line_a;
        logic delay_line_b;
        logic loss_line_a;
        logic loss_line_b;
        logic button_level;
    } in_item_t;

    typedef struct packed {
        logic [DELAY_W-1:0] delay_ms;
        logic [LOSS_W-1:0]  loss_percent;
        logic               burst_active;
        logic               indicator_on;
        logic               value_changed;
    } out_item_t;

    // detent direction seen by one knob on one sample
    typedef struct packed {
        logic up;
        logic down;
    } knob_step_t;

endpackage

[rtl/dqkt_knob.sv]
module dqkt_knob (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                line_a,
    input  logic                line_b,
    output dqkt_pkg::knob_step_t step
);

    logic a_level_reg, a_level_next;
    logic b_level_reg, b_level_next;
    logic a_before_reg, a_before_next;
    logic b_before_reg, b_before_next;
    logic a_chg, b_chg;
    logic det_a, det_b;

    always_comb
    begin
        // line a is taken first, line b sees the updated a state
        a_chg         = line_a != a_level_reg;
        a_before_next = a_chg ? a_level_reg : a_before_reg;
        a_level_next  = line_a;
        det_a = a_chg && !a_level_next && !b_level_reg && a_before_next && b_before_reg;

        b_chg         = line_b != b_level_reg;
        b_before_next = b_chg ? b_level_reg : b_before_reg;
        b_level_next  = line_b;
        det_b = b_chg && !a_level_next && !b_level_next && a_before_next && b_before_next;

        step.down = en && det_a;
        step.up   = en && det_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_level_reg  <= 1'b1;
            b_level_reg  <= 1'b1;
            a_before_reg <= 1'b0;
            b_before_reg <= 1'b0;
        end
        else if (en)
        begin
            a_level_reg  <= a_level_next;
            b_level_reg  <= b_level_next;
            a_before_reg <= a_before_next;
            b_before_reg <= b_before_next;
        end
    end

endmodule

[rtl/dual_quadrature_knob_tracker.sv]
// Dual quadrature knob tracker.
// Input channel (in_valid/in_ready/in_item) takes one sample of the delay knob
// lines, the loss knob lines and the active-low burst button per request.
// Output channel (out_valid/out_ready/out_item) returns one result per sample:
// delay count, loss count, burst flag, indicator and a changed flag.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the
// count limits; it is always ready and should be used only while idle.
// An accepted sample is held in the input register; its result is then loaded
// into the output register, which drives out_valid.
// Throughput: one sample per cycle unless the receiver stalls; the single
// decode/update pass between the input register and the output register sets that figure.
// When the receiver stalls, the result holds in the output register and one
// more sample waits in the input register; in_ready then drops.
// Reset clears both knob trackers (levels high, previous levels low), both
// counts to zero, and loads the default limits 0/10000 and 0/100.
module dual_quadrature_knob_tracker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  dqkt_pkg::in_item_t                   in_item,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output dqkt_pkg::out_item_t                  out_item,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  dqkt_pkg::cfg_index_t                 cfg_index,
    input  logic [dqkt_pkg::DELAY_W-1:0]         cfg_data
);

    logic                          in_valid_reg;
    dqkt_pkg::in_item_t            in_item_reg;
    logic                          out_valid_reg, out_valid_next;
    dqkt_pkg::out_item_t           out_item_reg, out_item_next;

    logic [dqkt_pkg::DELAY_W-1:0]  delay_min_reg, delay_max_reg;
    logic [dqkt_pkg::LOSS_W-1:0]   loss_min_reg, loss_max_reg;
    logic [dqkt_pkg::DELAY_W-1:0]  delay_count_reg, delay_count_next;
    logic [dqkt_pkg::LOSS_W-1:0]   loss_count_reg, loss_count_next;

    logic                          out_free, advance, knob_en, burst;
    dqkt_pkg::knob_step_t          delay_step, loss_step;
    logic [dqkt_pkg::STEP_W-1:0]   step_up, step_down;
    logic [dqkt_pkg::DELAY_W:0]    delay_sum;

    assign out_free  = !out_valid_reg || out_ready;
    assign advance   = in_valid_reg && out_free;
    assign in_ready  = !in_valid_reg || out_free;
    assign burst     = !in_item_reg.button_level;
    assign knob_en   = advance && !burst;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    dqkt_knob u_delay_knob (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (knob_en),
        .line_a (in_item_reg.delay_line_a),
        .line_b (in_item_reg.delay_line_b),
        .step   (delay_step)
    );

    dqkt_knob u_loss_knob (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (knob_en),
        .line_a (in_item_reg.loss_line_a),
        .line_b (in_item_reg.loss_line_b),
        .step   (loss_step)
    );

    always_comb
    begin
        // step size grows with magnitude; going down the boundary value keeps the finer step
        if (delay_count_reg < dqkt_pkg::DELAY_FINE_TOP)
            step_up = dqkt_pkg::STEP_FINE;
        else if (delay_count_reg < dqkt_pkg::DELAY_MID_TOP)
            step_up = dqkt_pkg::STEP_MID;
        else
            step_up = dqkt_pkg::STEP_COARSE;

        if (delay_count_reg <= dqkt_pkg::DELAY_FINE_TOP)
            step_down = dqkt_pkg::STEP_FINE;
        else if (delay_count_reg <= dqkt_pkg::DELAY_MID_TOP)
            step_down = dqkt_pkg::STEP_MID;
        else
            step_down = dqkt_pkg::STEP_COARSE;

        delay_sum = {1'b0, delay_count_reg} + (dqkt_pkg::DELAY_W+1)'(step_up);

        delay_count_next = delay_count_reg;
        if (delay_step.down && (delay_count_reg > delay_min_reg))
            delay_count_next = delay_count_reg - dqkt_pkg::DELAY_W'(step_down);
        else if (delay_step.up && (delay_count_reg < delay_max_reg))
        begin
            if (delay_sum > {1'b0, dqkt_pkg::DELAY_FULL})
                delay_count_next = dqkt_pkg::DELAY_FULL;
            else
                delay_count_next = delay_sum[dqkt_pkg::DELAY_W-1:0];
        end

        loss_count_next = loss_count_reg;
        if (loss_step.down && (loss_count_reg > loss_min_reg))
            loss_count_next = loss_count_reg - dqkt_pkg::LOSS_W'(1);
        else if (loss_step.up && (loss_count_reg < loss_max_reg))
            loss_count_next = loss_count_reg + dqkt_pkg::LOSS_W'(1);

        out_item_next.delay_ms      = delay_count_next;
        out_item_next.loss_percent  = loss_count_next;
        out_item_next.burst_active  = burst;
        out_item_next.indicator_on  = burst || (delay_count_next != '0)
                                      || (loss_count_next != '0);
        out_item_next.value_changed = (delay_count_next != delay_count_reg)
                                      || (loss_count_next != loss_count_reg);

        if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            delay_count_reg <= '0;
            loss_count_reg  <= '0;
            delay_min_reg   <= dqkt_pkg::DELAY_MIN_RST;
            delay_max_reg   <= dqkt_pkg::DELAY_MAX_RST;
            loss_min_reg    <= dqkt_pkg::LOSS_MIN_RST;
            loss_max_reg    <= dqkt_pkg::LOSS_MAX_RST;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                delay_count_reg <= delay_count_next;
                loss_count_reg  <= loss_count_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    dqkt_pkg::CFG_DELAY_MIN: delay_min_reg <= cfg_data;
                    dqkt_pkg::CFG_DELAY_MAX: delay_max_reg <= cfg_data;
                    dqkt_pkg::CFG_LOSS_MIN:  loss_min_reg  <= cfg_data[dqkt_pkg::LOSS_W-1:0];
                    dqkt_pkg::CFG_LOSS_MAX:  loss_max_reg  <= cfg_data[dqkt_pkg::LOSS_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_item_reg <= in_item;
        if (advance)
            out_item_reg <= out_item_next;
    end

endmodule

[rtl/dqkt_checker.sv]
module dqkt_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  dqkt_pkg::out_item_t          out_item
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");

    // knobs are frozen during burst
    a_burst_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.burst_active |-> !out_item.value_changed)
        else $error("count moved during burst");

    a_indicator: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.indicator_on == (out_item.burst_active
            || (out_item.delay_ms != '0) || (out_item.loss_percent != '0)))
        else $error("indicator does not match counts");

    // a new result must come from an accepted sample
    a_first_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2) || $past(!in_ready))
        else $error("result without an accepted sample");

endmodule

bind dual_quadrature_knob_tracker dqkt_checker u_dqkt_checker (.*);

[verif/tb_dual_quadrature_knob_tracker.sv]
`timescale 1ns / 1ps

module tb_dual_quadrature_knob_tracker;

    localparam int SETTLE_CYCLES = 6;
    localparam int STALL_LIMIT   = 3000;
    localparam int LONG_HOLD     = 120;
    localparam int LONG_HOLD_AT  = 300;
    localparam int PRINT_CAP     = 100;

    // {delay a, delay b, loss a, loss b, button}
    localparam logic [4:0] OPENING [20] = '{
        5'b11_11_1, 5'b11_11_0, 5'b00_00_0, 5'b11_11_1, 5'b01_01_1,
        5'b00_00_1, 5'b10_10_1, 5'b11_11_1, 5'b10_01_1, 5'b00_00_1,
        5'b01_10_1, 5'b11_11_1, 5'b10_10_1, 5'b00_00_1, 5'b11_11_1,
        5'b00_00_1, 5'b11_11_1, 5'b01_01_0, 5'b00_00_1, 5'b11_11_1
    };

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic                          in_ready;
    dqkt_pkg::in_item_t            in_item   = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    dqkt_pkg::out_item_t           out_item;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    dqkt_pkg::cfg_index_t          cfg_index = dqkt_pkg::CFG_DELAY_MIN;
    logic [dqkt_pkg::DELAY_W-1:0]  cfg_data  = '0;

    dual_quadrature_knob_tracker u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    dqkt_pkg::in_item_t  samples_to_send [$];
    dqkt_pkg::out_item_t knob_readings_due [$];
    int                  mismatch_count = 0;

    // knob tracker mirror
    logic               dly_a = 1'b1, dly_b = 1'b1, dly_a_was = 1'b0, dly_b_was = 1'b0;
    logic               los_a = 1'b1, los_b = 1'b1, los_a_was = 1'b0, los_b_was = 1'b0;
    logic [dqkt_pkg::DELAY_W-1:0] delay_now = '0;
    logic [dqkt_pkg::DELAY_W-1:0] delay_floor = dqkt_pkg::DELAY_MIN_RST;
    logic [dqkt_pkg::DELAY_W-1:0] delay_ceil = dqkt_pkg::DELAY_MAX_RST;
    logic [dqkt_pkg::LOSS_W-1:0]  loss_now = '0;
    logic [dqkt_pkg::LOSS_W-1:0]  loss_floor = dqkt_pkg::LOSS_MIN_RST;
    logic [dqkt_pkg::LOSS_W-1:0]  loss_ceil = dqkt_pkg::LOSS_MAX_RST;

    // gesture planning for the stimulus, knob 0 delay, knob 1 loss
    logic [1:0] knob_now [2] = '{2'b11, 2'b11};
    logic [7:0] knob_plan [2] = '{8'd0, 8'd0};
    int         plan_len [2] = '{0, 0};

    function automatic logic is_detent(logic a, logic b, logic a_was, logic b_was);
        return !a && !b && a_was && b_was;
    endfunction

    function automatic dqkt_pkg::out_item_t track_knobs(dqkt_pkg::in_item_t s);
        dqkt_pkg::out_item_t          r;
        logic [dqkt_pkg::DELAY_W-1:0] old_delay;
        logic [dqkt_pkg::LOSS_W-1:0]  old_loss;
        logic [dqkt_pkg::STEP_W-1:0]  stride;
        int                           sum;
        old_delay = delay_now;
        old_loss = loss_now;
        if (s.button_level)
        begin
            // line a is handled before line b, so a double change counts as b last
            if (s.delay_line_a != dly_a)
            begin
                dly_a_was = dly_a;
                dly_a = s.delay_line_a;
                if (is_detent(dly_a, dly_b, dly_a_was, dly_b_was) && delay_now > delay_floor)
                begin
                    if (delay_now <= dqkt_pkg::DELAY_FINE_TOP)
                        stride = dqkt_pkg::STEP_FINE;
                    else if (delay_now <= dqkt_pkg::DELAY_MID_TOP)
                        stride = dqkt_pkg::STEP_MID;
                    else
                        stride = dqkt_pkg::STEP_COARSE;
                    delay_now = delay_now - dqkt_pkg::DELAY_W'(stride);
                end
            end
            if (s.delay_line_b != dly_b)
            begin
                dly_b_was = dly_b;
                dly_b = s.delay_line_b;
                if (is_detent(dly_a, dly_b, dly_a_was, dly_b_was) && delay_now < delay_ceil)
                begin
                    if (delay_now < dqkt_pkg::DELAY_FINE_TOP)
                        stride = dqkt_pkg::STEP_FINE;
                    else if (delay_now < dqkt_pkg::DELAY_MID_TOP)
                        stride = dqkt_pkg::STEP_MID;
                    else
                        stride = dqkt_pkg::STEP_COARSE;
                    sum = int'(delay_now) + int'(stride);
                    // a coarse step near the top clips at the counter width
                    delay_now = (sum > int'(dqkt_pkg::DELAY_FULL)) ? dqkt_pkg::DELAY_FULL
                                                                   : dqkt_pkg::DELAY_W'(sum);
                end
            end
            if (s.loss_line_a != los_a)
            begin
                los_a_was = los_a;
                los_a = s.loss_line_a;
                if (is_detent(los_a, los_b, los_a_was, los_b_was) && loss_now > loss_floor)
                    loss_now = loss_now - dqkt_pkg::LOSS_W'(1);
            end
            if (s.loss_line_b != los_b)
            begin
                los_b_was = los_b;
                los_b = s.loss_line_b;
                if (is_detent(los_a, los_b, los_a_was, los_b_was) && loss_now < loss_ceil)
                    loss_now = loss_now + dqkt_pkg::LOSS_W'(1);
            end
        end
        r.delay_ms = delay_now;
        r.loss_percent = loss_now;
        r.burst_active = !s.button_level;
        r.indicator_on = !s.button_level || delay_now != '0 || loss_now != '0;
        r.value_changed = delay_now != old_delay || loss_now != old_loss;
        return r;
    endfunction

    // mostly short gaps, a few long ones, and now and then a calm stretch with none
    function automatic int pick_idle(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(99);
        if (r < 3)
        begin
            calm = $urandom_range(30, 80);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    // line levels {a, b} of one turn, first step in the low bits
    function automatic int plan_gesture(int up_pct, int down_pct, int jump_pct,
                                        output logic [7:0] steps);
        int r;
        r = $urandom_range(99);
        steps = '0;
        if (r < up_pct)
        begin
            if ($urandom_range(99) < jump_pct)
            begin
                steps = 8'b00_00_11_00;
                return 2;
            end
            if ($urandom_range(1))
            begin
                steps = 8'b11_10_00_01;
                return 4;
            end
            steps = 8'b00_11_00_01;
            return 3;
        end
        if (r < up_pct + down_pct)
        begin
            if ($urandom_range(1))
            begin
                steps = 8'b11_01_00_10;
                return 4;
            end
            steps = 8'b00_11_00_10;
            return 3;
        end
        steps = 8'($urandom);
        return $urandom_range(1, 3);
    endfunction

    task automatic queue_random(int count, int up_pct, int down_pct, int jump_pct);
        dqkt_pkg::in_item_t s;
        for (int i = 0; i < count; i++)
        begin
            for (int k = 0; k < 2; k++)
            begin
                // occasionally repeat the current levels
                if ($urandom_range(99) >= 6)
                begin
                    if (plan_len[k] == 0)
                        plan_len[k] = plan_gesture(up_pct, down_pct, jump_pct, knob_plan[k]);
                    knob_now[k] = knob_plan[k][1:0];
                    knob_plan[k] = knob_plan[k] >> 2;
                    plan_len[k]--;
                end
            end
            s.delay_line_a = knob_now[0][1];
            s.delay_line_b = knob_now[0][0];
            s.loss_line_a = knob_now[1][1];
            s.loss_line_b = knob_now[1][0];
            s.button_level = $urandom_range(99) >= 5;
            samples_to_send.push_back(s);
        end
    endtask

    task automatic write_limit(dqkt_pkg::cfg_index_t idx,
                               logic [dqkt_pkg::DELAY_W-1:0] data);
        @(posedge clk);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            dqkt_pkg::CFG_DELAY_MIN: delay_floor = data;
            dqkt_pkg::CFG_DELAY_MAX: delay_ceil = data;
            dqkt_pkg::CFG_LOSS_MIN:  loss_floor = data[dqkt_pkg::LOSS_W-1:0];
            dqkt_pkg::CFG_LOSS_MAX:  loss_ceil = data[dqkt_pkg::LOSS_W-1:0];
            default: ;
        endcase
    endtask

    // sender holds back until every request has come back
    task automatic drain();
        do
            @(negedge clk);
        while (samples_to_send.size() != 0 || in_valid || knob_readings_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic flag_mismatch(string what);
        if (mismatch_count < PRINT_CAP)
            $display("ERROR at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    // driver
    logic sent_now;
    int   tx_wait = 0;
    int   tx_calm = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            sent_now = in_valid && in_ready;
            if (sent_now)
                knob_readings_due.push_back(track_knobs(in_item));
            if (!in_valid || sent_now)
            begin
                if (tx_wait > 0)
                begin
                    tx_wait--;
                    in_valid <= 1'b0;
                end
                else if (samples_to_send.size() != 0)
                begin
                    in_item <= samples_to_send.pop_front();
                    in_valid <= 1'b1;
                    tx_wait = pick_idle(tx_calm);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: checks results and drives ready
    dqkt_pkg::out_item_t want;
    int                  readings_taken = 0;
    int                  rx_hold = 0;
    int                  rx_calm = 0;
    int                  rx_idle;
    logic                long_hold_done = 1'b0;

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                readings_taken++;
                if (knob_readings_due.size() == 0)
                    flag_mismatch($sformatf("result with none due: delay %0d loss %0d",
                                            out_item.delay_ms, out_item.loss_percent));
                else
                begin
                    want = knob_readings_due.pop_front();
                    if (out_item.delay_ms !== want.delay_ms)
                        flag_mismatch($sformatf("delay_ms %0d, want %0d",
                                                out_item.delay_ms, want.delay_ms));
                    if (out_item.loss_percent !== want.loss_percent)
                        flag_mismatch($sformatf("loss_percent %0d, want %0d",
                                                out_item.loss_percent, want.loss_percent));
                    if (out_item.burst_active !== want.burst_active)
                        flag_mismatch($sformatf("burst_active %b, want %b",
                                                out_item.burst_active, want.burst_active));
                    if (out_item.indicator_on !== want.indicator_on)
                        flag_mismatch($sformatf("indicator_on %b, want %b",
                                                out_item.indicator_on, want.indicator_on));
                    if (out_item.value_changed !== want.value_changed)
                        flag_mismatch($sformatf("value_changed %b, want %b",
                                                out_item.value_changed, want.value_changed));
                end
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                out_ready <= 1'b0;
            end
            else if (!long_hold_done && readings_taken >= LONG_HOLD_AT)
            begin
                // long back-pressure so the input side fills and stalls
                long_hold_done = 1'b1;
                rx_hold = LONG_HOLD;
                out_ready <= 1'b0;
            end
            else
            begin
                rx_idle = pick_idle(rx_calm);
                if (rx_idle > 0)
                begin
                    rx_hold = rx_idle - 1;
                    out_ready <= 1'b0;
                end
                else
                    out_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no request moving on any channel
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [dqkt_pkg::LOSS_W-1:0] junk;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (OPENING[i])
            samples_to_send.push_back(dqkt_pkg::in_item_t'(OPENING[i]));
        drain();

        // climb toward the top of both ranges
        junk = dqkt_pkg::LOSS_W'($urandom);
        write_limit(dqkt_pkg::CFG_DELAY_MIN, 14'd0);
        write_limit(dqkt_pkg::CFG_DELAY_MAX, dqkt_pkg::DELAY_FULL);
        write_limit(dqkt_pkg::CFG_LOSS_MIN, 14'd0);
        write_limit(dqkt_pkg::CFG_LOSS_MAX, {junk, 7'd127});
        queue_random(850, 92, 3, 80);
        drain();

        // come down through the coarse range, overshooting the floor
        write_limit(dqkt_pkg::CFG_DELAY_MIN, 14'd950);
        write_limit(dqkt_pkg::CFG_DELAY_MAX, 14'd10000);
        write_limit(dqkt_pkg::CFG_LOSS_MIN, 14'd100);
        write_limit(dqkt_pkg::CFG_LOSS_MAX, 14'd100);
        queue_random(450, 3, 92, 50);
        drain();

        // all limits zero: counts only fall
        write_limit(dqkt_pkg::CFG_DELAY_MIN, 14'd0);
        write_limit(dqkt_pkg::CFG_DELAY_MAX, 14'd0);
        write_limit(dqkt_pkg::CFG_LOSS_MIN, 14'd0);
        write_limit(dqkt_pkg::CFG_LOSS_MAX, 14'd0);
        queue_random(250, 5, 90, 50);
        drain();

        junk = dqkt_pkg::LOSS_W'($urandom);
        write_limit(dqkt_pkg::CFG_DELAY_MIN, 14'd50);
        write_limit(dqkt_pkg::CFG_DELAY_MAX, 14'd120);
        write_limit(dqkt_pkg::CFG_LOSS_MIN, {junk, 7'd10});
        write_limit(dqkt_pkg::CFG_LOSS_MAX, 14'd90);
        queue_random(150, 45, 45, 40);
        drain();

        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
